/* rtl/core/dpb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types and constants for the depth back-projection core.
// ----------------------------------------------------------------------------
package dpb_pkg;

	localparam int CNT_W    = 12;   // pixel column and row as used by the math
	localparam int STEP_W   = $clog2(CNT_W);
	localparam int WIDTH_W  = 13;
	localparam int DS_W     = 5;
	localparam int DEPTH_W  = 16;
	localparam int CTR_W    = 16;
	localparam int GAIN_W   = 24;
	localparam int MAG_W    = 16;
	localparam int MUL_A_W  = 40;
	localparam int MUL_B_W  = 16;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int Q_W      = ACC_W - 12;
	localparam int COORD_W  = 32;
	localparam int COLOR_W  = 24;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 3 * COORD_W + COLOR_W;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_DOWNSAMPLE   = 3'd1,
		REG_CENTER_X     = 3'd2,
		REG_CENTER_Y     = 3'd3,
		REG_INV_FOCAL_X  = 3'd4,
		REG_INV_FOCAL_Y  = 3'd5,
		REG_DEPTH_FACTOR = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REM,
		ST_CHK,
		ST_Z,
		ST_MX,
		ST_MY,
		ST_XLO,
		ST_XHI,
		ST_YLO,
		ST_YHI,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_REM,
		OP_Z,
		OP_MX,
		OP_MY,
		OP_XLO,
		OP_XHI,
		OP_YLO,
		OP_YHI,
		OP_LOAD
	} op_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] image_width;
		logic [DS_W-1:0]    downsample;
		logic [CTR_W-1:0]   center_x;
		logic [CTR_W-1:0]   center_y;
		logic [GAIN_W-1:0]  inv_focal_x;
		logic [GAIN_W-1:0]  inv_focal_y;
		logic [GAIN_W-1:0]  depth_factor;
	} cfg_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/dpb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_ctrl
// Sequencer: accept, bit-serial downsample check, multiply steps, load.
// ----------------------------------------------------------------------------
module dpb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dpb_pkg::sts_t     sts,
	output dpb_pkg::cmd_t     cmd
);

	dpb_pkg::state_t state_q, state_d;
	logic [dpb_pkg::STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpb_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_ready = 1'b0;
		cmd.op   = dpb_pkg::OP_NONE;
		unique case (state_q)
			dpb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = dpb_pkg::OP_ACCEPT;
					step_d  = '0;
					state_d = dpb_pkg::ST_REM;
				end
			end
			dpb_pkg::ST_REM: begin
				cmd.op = dpb_pkg::OP_REM;
				if (step_q == dpb_pkg::STEP_W'(dpb_pkg::CNT_W - 1)) begin
					state_d = dpb_pkg::ST_CHK;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			dpb_pkg::ST_CHK: begin
				state_d = sts.keep ? dpb_pkg::ST_Z : dpb_pkg::ST_IDLE;
			end
			dpb_pkg::ST_Z: begin
				cmd.op  = dpb_pkg::OP_Z;
				state_d = dpb_pkg::ST_MX;
			end
			dpb_pkg::ST_MX: begin
				cmd.op  = dpb_pkg::OP_MX;
				state_d = dpb_pkg::ST_MY;
			end
			dpb_pkg::ST_MY: begin
				cmd.op  = dpb_pkg::OP_MY;
				state_d = dpb_pkg::ST_XLO;
			end
			dpb_pkg::ST_XLO: begin
				cmd.op  = dpb_pkg::OP_XLO;
				state_d = dpb_pkg::ST_XHI;
			end
			dpb_pkg::ST_XHI: begin
				cmd.op  = dpb_pkg::OP_XHI;
				state_d = dpb_pkg::ST_YLO;
			end
			dpb_pkg::ST_YLO: begin
				cmd.op  = dpb_pkg::OP_YLO;
				state_d = dpb_pkg::ST_YHI;
			end
			dpb_pkg::ST_YHI: begin
				cmd.op  = dpb_pkg::OP_YHI;
				state_d = dpb_pkg::ST_FIN;
			end
			dpb_pkg::ST_FIN: begin
				// wait here while the output word is still held
				if (sts.out_free) begin
					cmd.op  = dpb_pkg::OP_LOAD;
					state_d = dpb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/dpb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_datapath
// Raster counters, remainder lanes, shared 40x16 multiplier and output word.
// ----------------------------------------------------------------------------
module dpb_datapath #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dpb_pkg::cfg_t                cfg,
	input  dpb_pkg::cmd_t                cmd,
	output dpb_pkg::sts_t                sts,
	input  logic                         in_start,
	input  logic [dpb_pkg::DEPTH_W-1:0]  in_depth,
	input  logic [dpb_pkg::COLOR_W-1:0]  in_color,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dpb_pkg::OUT_DW-1:0]   out_data,
	output logic                         out_user
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic [dpb_pkg::ACC_W-1:0] RND = dpb_pkg::ACC_W'(1) << 27;

	// raster counters
	logic [CW-1:0] col_q, col_eff, col_d;
	logic [RW-1:0] row_q, row_eff, row_d;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic [dpb_pkg::WIDTH_W-1:0] w_eff;
	logic [dpb_pkg::DS_W-1:0]    ds_eff;

	// per-pixel registers
	logic [dpb_pkg::CNT_W-1:0]   pix_col_q, pix_row_q, col_sh_q, row_sh_q;
	logic [dpb_pkg::DS_W-1:0]    rem_c_q, rem_r_q;
	logic [dpb_pkg::DS_W:0]      tc, tr;
	logic [dpb_pkg::DEPTH_W-1:0] depth_q;
	logic [dpb_pkg::COLOR_W-1:0] color_q;

	// arithmetic
	logic [dpb_pkg::MAG_W:0]     dx, dy, ndx, ndy;
	logic                        negx, negy;
	logic [dpb_pkg::MAG_W-1:0]   magx, magy;
	logic [dpb_pkg::MUL_A_W-1:0] mul_a, mx_q, my_q;
	logic [dpb_pkg::MUL_B_W-1:0] mul_b;
	logic [dpb_pkg::PROD_W-1:0]  prod_q;
	logic [dpb_pkg::ACC_W-1:0]   acc_q, qsum;
	logic [dpb_pkg::Q_W-1:0]     qmag;
	logic [dpb_pkg::MUL_A_W:0]   zround;
	logic [dpb_pkg::COORD_W-1:0] zq_q, x_res_q, qsat;
	logic                        pt_valid;

	logic                        out_valid_q, out_user_q;
	logic [dpb_pkg::OUT_DW-1:0]  out_data_q;

	function automatic logic [dpb_pkg::COORD_W-1:0] sat_axis(
		input logic [dpb_pkg::Q_W-1:0] q,
		input logic                    neg
	);
		logic [dpb_pkg::COORD_W-1:0] r;
		if (neg) begin
			if (q >= (dpb_pkg::Q_W'(1) << 31)) r = 32'h8000_0000;
			else r = 32'h0 - q[dpb_pkg::COORD_W-1:0];
		end else begin
			if (q > dpb_pkg::Q_W'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
			else r = q[dpb_pkg::COORD_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		if (cfg.image_width == '0) w_eff = dpb_pkg::WIDTH_W'(1);
		else if (cfg.image_width > dpb_pkg::WIDTH_W'(MAX_WIDTH))
			w_eff = dpb_pkg::WIDTH_W'(MAX_WIDTH);
		else w_eff = cfg.image_width;
		ds_eff  = (cfg.downsample == '0) ? dpb_pkg::DS_W'(1) : cfg.downsample;

		col_eff = in_start ? '0 : col_q;
		row_eff = in_start ? '0 : row_q;
		col_inc = {1'b0, col_eff} + 1'b1;
		row_inc = {1'b0, row_eff} + 1'b1;
		if (dpb_pkg::WIDTH_W'(col_inc) >= w_eff) begin
			col_d = '0;
			row_d = (row_inc >= (RW + 1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
		end else begin
			col_d = col_inc[CW-1:0];
			row_d = row_eff;
		end

		// restoring remainder step, one count bit per cycle
		tc = {rem_c_q, col_sh_q[dpb_pkg::CNT_W-1]};
		tr = {rem_r_q, row_sh_q[dpb_pkg::CNT_W-1]};
		if (tc >= {1'b0, ds_eff}) tc = tc - {1'b0, ds_eff};
		if (tr >= {1'b0, ds_eff}) tr = tr - {1'b0, ds_eff};

		// signed Q12.4 offsets from the principal point
		dx   = {1'b0, pix_col_q, 4'b0} - {1'b0, cfg.center_x};
		dy   = {1'b0, pix_row_q, 4'b0} - {1'b0, cfg.center_y};
		ndx  = '0 - dx;
		ndy  = '0 - dy;
		negx = dx[dpb_pkg::MAG_W];
		negy = dy[dpb_pkg::MAG_W];
		magx = negx ? ndx[dpb_pkg::MAG_W-1:0] : dx[dpb_pkg::MAG_W-1:0];
		magy = negy ? ndy[dpb_pkg::MAG_W-1:0] : dy[dpb_pkg::MAG_W-1:0];

		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			dpb_pkg::OP_Z: begin
				mul_a = dpb_pkg::MUL_A_W'(cfg.depth_factor);
				mul_b = depth_q;
			end
			dpb_pkg::OP_MX: begin
				mul_a = dpb_pkg::MUL_A_W'(cfg.inv_focal_x);
				mul_b = magx;
			end
			dpb_pkg::OP_MY: begin
				mul_a = dpb_pkg::MUL_A_W'(cfg.inv_focal_y);
				mul_b = magy;
			end
			dpb_pkg::OP_XLO: begin
				mul_a = mx_q;
				mul_b = zq_q[15:0];
			end
			dpb_pkg::OP_XHI: begin
				mul_a = mx_q;
				mul_b = zq_q[31:16];
			end
			dpb_pkg::OP_YLO: begin
				mul_a = my_q;
				mul_b = zq_q[15:0];
			end
			dpb_pkg::OP_YHI: begin
				mul_a = my_q;
				mul_b = zq_q[31:16];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		zround = {1'b0, prod_q[dpb_pkg::MUL_A_W-1:0]} + dpb_pkg::MUL_A_W'(128);
		// (hi + ((lo + 2^27) >> 16)) >> 12
		qsum = dpb_pkg::ACC_W'(prod_q) + (acc_q >> 16);
		qmag = qsum[dpb_pkg::ACC_W-1:12];
		qsat = sat_axis(qmag, (cmd.op == dpb_pkg::OP_YLO) ? negx : negy);
		pt_valid = depth_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == dpb_pkg::OP_ACCEPT) begin
				col_q <= col_d;
				row_q <= row_d;
			end
			if (cmd.op == dpb_pkg::OP_LOAD) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dpb_pkg::OP_ACCEPT: begin
				pix_col_q <= dpb_pkg::CNT_W'(col_eff);
				pix_row_q <= dpb_pkg::CNT_W'(row_eff);
				col_sh_q  <= dpb_pkg::CNT_W'(col_eff);
				row_sh_q  <= dpb_pkg::CNT_W'(row_eff);
				rem_c_q   <= '0;
				rem_r_q   <= '0;
				depth_q   <= in_depth;
				color_q   <= in_color;
			end
			dpb_pkg::OP_REM: begin
				rem_c_q  <= tc[dpb_pkg::DS_W-1:0];
				rem_r_q  <= tr[dpb_pkg::DS_W-1:0];
				col_sh_q <= col_sh_q << 1;
				row_sh_q <= row_sh_q << 1;
			end
			dpb_pkg::OP_MX: zq_q <= zround[dpb_pkg::MUL_A_W-1:8];
			dpb_pkg::OP_MY: mx_q <= prod_q[dpb_pkg::MUL_A_W-1:0];
			dpb_pkg::OP_XLO: my_q <= prod_q[dpb_pkg::MUL_A_W-1:0];
			dpb_pkg::OP_XHI, dpb_pkg::OP_YHI: acc_q <= dpb_pkg::ACC_W'(prod_q) + RND;
			dpb_pkg::OP_YLO: x_res_q <= qsat;
			dpb_pkg::OP_LOAD: begin
				out_user_q <= pt_valid;
				out_data_q <= {color_q,
					pt_valid ? zq_q : '0,
					pt_valid ? qsat : '0,
					pt_valid ? x_res_q : '0};
			end
			default: begin
			end
		endcase
		if (cmd.op == dpb_pkg::OP_Z || cmd.op == dpb_pkg::OP_MX ||
		    cmd.op == dpb_pkg::OP_MY || cmd.op == dpb_pkg::OP_XLO ||
		    cmd.op == dpb_pkg::OP_XHI || cmd.op == dpb_pkg::OP_YLO ||
		    cmd.op == dpb_pkg::OP_YHI) begin
			prod_q <= mul_a * mul_b;
		end
	end

	assign sts.keep     = (rem_c_q == '0) && (rem_r_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_user     = out_user_q;

endmodule

/* rtl/core/depth_pixel_to_point_backprojection_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point_backprojection_core
// Pinhole back-projection of a raster depth/color stream into 3D points.
// ----------------------------------------------------------------------------
// Input words (s_*): one pixel each, raster order; s_tuser[0] marks the first
// pixel of a frame and clears the column and row count. Output words (m_*):
// one point for each pixel whose column and row are multiples of downsample;
// m_tuser[0] is low when depth was zero, coordinates then zero.
// Configuration through the APB port, register i at byte address 4*i, only
// while no pixel is in flight.
// Sequence: a kept pixel passes through accept, a bit-serial remainder check,
// one check step, seven steps of the shared 40x16 multiplier and one load; a
// dropped pixel ends after the check step. The core is ready for the next
// pixel in the cycle after that. The output register holds a finished point
// while the next pixel is processed; if m_tready stays low the core waits
// before loading the next one.
// Reset: registers return to their defaults, counts to zero, output empty.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_backprojection_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [dpb_pkg::IN_DW-1:0]   s_tdata,  // depth[15:0], red, green, blue
	input  logic [0:0]                  s_tuser,  // frame_start
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [dpb_pkg::OUT_DW-1:0]  m_tdata,  // point_x, point_y, point_z, packed_color
	output logic [0:0]                  m_tuser,  // point_valid
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dpb_pkg::APB_AW-1:0]  paddr,
	input  logic [dpb_pkg::APB_DW-1:0]  pwdata,
	output logic [dpb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	dpb_pkg::cfg_t cfg_q;
	dpb_pkg::cmd_t cmd;
	dpb_pkg::sts_t sts;
	logic          wr_en;
	logic [2:0]    reg_sel;
	logic          in_ready;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= dpb_pkg::WIDTH_W'(640);
			cfg_q.downsample   <= dpb_pkg::DS_W'(1);
			cfg_q.center_x     <= dpb_pkg::CTR_W'(5120);
			cfg_q.center_y     <= dpb_pkg::CTR_W'(3840);
			cfg_q.inv_focal_x  <= dpb_pkg::GAIN_W'(32263);
			cfg_q.inv_focal_y  <= dpb_pkg::GAIN_W'(32263);
			cfg_q.depth_factor <= dpb_pkg::GAIN_W'(16777);
		end else if (wr_en) begin
			case (reg_sel)
				dpb_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[dpb_pkg::WIDTH_W-1:0];
				dpb_pkg::REG_DOWNSAMPLE:   cfg_q.downsample   <= pwdata[dpb_pkg::DS_W-1:0];
				dpb_pkg::REG_CENTER_X:     cfg_q.center_x     <= pwdata[dpb_pkg::CTR_W-1:0];
				dpb_pkg::REG_CENTER_Y:     cfg_q.center_y     <= pwdata[dpb_pkg::CTR_W-1:0];
				dpb_pkg::REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= pwdata[dpb_pkg::GAIN_W-1:0];
				dpb_pkg::REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= pwdata[dpb_pkg::GAIN_W-1:0];
				dpb_pkg::REG_DEPTH_FACTOR: cfg_q.depth_factor <= pwdata[dpb_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			dpb_pkg::REG_IMAGE_WIDTH:  prdata = dpb_pkg::APB_DW'(cfg_q.image_width);
			dpb_pkg::REG_DOWNSAMPLE:   prdata = dpb_pkg::APB_DW'(cfg_q.downsample);
			dpb_pkg::REG_CENTER_X:     prdata = dpb_pkg::APB_DW'(cfg_q.center_x);
			dpb_pkg::REG_CENTER_Y:     prdata = dpb_pkg::APB_DW'(cfg_q.center_y);
			dpb_pkg::REG_INV_FOCAL_X:  prdata = dpb_pkg::APB_DW'(cfg_q.inv_focal_x);
			dpb_pkg::REG_INV_FOCAL_Y:  prdata = dpb_pkg::APB_DW'(cfg_q.inv_focal_y);
			dpb_pkg::REG_DEPTH_FACTOR: prdata = dpb_pkg::APB_DW'(cfg_q.depth_factor);
			default:                   prdata = '0;
		endcase
	end

	dpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dpb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.in_start  (s_tuser[0]),
		.in_depth  (s_tdata[15:0]),
		.in_color  ({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser[0])
	);

	assign s_tready = in_ready;

	// one pixel at a time: no accept right after an accept
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("pixel accepted while previous one in flight");

	// invalid point carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[95:0] == '0)
		else $error("invalid point with nonzero coordinates");

	// a new point is only loaded from the final sequencer step
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("output loaded while core idle");

endmodule

/* tb/tb_depth_pixel_to_point_backprojection_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_point_backprojection_core
// Self-checking bench for the depth back-projection core: a queue-fed pixel
// driver and a point monitor run against an in-bench fixed-point predictor,
// over directed extremes and randomly configured frame phases with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_point_backprojection_core;

	localparam int FRAME_MAX_W   = 4096;
	localparam int FRAME_MAX_H   = 4096;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_PIXELS  = 95;

	typedef struct {
		logic        frame_start;
		logic [15:0] depth;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pixel_t;

	typedef struct {
		logic        valid;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [23:0] color;
	} point_t;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [dpb_pkg::IN_DW-1:0]  s_tdata  = '0;      // depth, red, green, blue
	logic [0:0]                 s_tuser  = '0;      // frame_start
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [dpb_pkg::OUT_DW-1:0] m_tdata;            // point_x, point_y, point_z, packed_color
	logic [0:0]                 m_tuser;            // point_valid
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [dpb_pkg::APB_AW-1:0] paddr    = '0;
	logic [dpb_pkg::APB_DW-1:0] pwdata   = '0;
	logic [dpb_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	depth_pixel_to_point_backprojection_core #(
		.MAX_WIDTH (FRAME_MAX_W),
		.MAX_HEIGHT(FRAME_MAX_H)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	dpb_pkg::cfg_t cam_cfg;
	logic [11:0]   col_cnt;
	logic [11:0]   row_cnt;

	pixel_t pixel_q[$];
	point_t point_q[$];
	pixel_t pixel_on_bus;

	int send_idle_pct = 37;
	int recv_idle_pct = 64;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int n_pixels      = 0;
	int n_points      = 0;
	int n_no_depth    = 0;
	int n_writes      = 0;
	int n_err         = 0;
	int cycles        = 0;

	function automatic int eff_width();
		int w;
		w = cam_cfg.image_width;
		if (w == 0)
			w = 1;
		if (w > FRAME_MAX_W)
			w = FRAME_MAX_W;
		return w;
	endfunction

	// one axis: |offset| * gain * z, Q.44 rounded to Q16.16, sign restored
	function automatic logic [31:0] axis_coord(logic [11:0] cnt, logic [15:0] ctr,
						   logic [23:0] gain, logic [31:0] z);
		logic signed [17:0] d;
		logic [17:0]        dm;
		logic [63:0]        mag, m, lo, hi, q;
		d   = $signed({2'b00, cnt, 4'b0000}) - $signed({2'b00, ctr});
		dm  = d[17] ? -d : d;
		mag = {46'd0, dm};
		m   = mag * gain;
		lo  = m * z[15:0];
		hi  = m * z[31:16];
		q   = (hi + ((lo + 64'd134217728) >> 16)) >> 12;
		if (d[17]) begin
			if (q >= 64'h8000_0000)
				return 32'h8000_0000;
			q = -q;
			return q[31:0];
		end
		if (q > 64'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic void predict_pixel(pixel_t px);
		int          width, ds, col, row;
		logic [63:0] p;
		point_t      pt;
		width = eff_width();
		ds    = (cam_cfg.downsample == 0) ? 1 : cam_cfg.downsample;
		if (px.frame_start) begin
			col_cnt = '0;
			row_cnt = '0;
		end
		col = col_cnt;
		row = row_cnt;
		if (col % ds == 0 && row % ds == 0) begin
			pt.valid = px.depth != 0;
			pt.x     = '0;
			pt.y     = '0;
			pt.z     = '0;
			if (pt.valid) begin
				p    = px.depth;
				p    = p * cam_cfg.depth_factor;
				p    = (p + 64'd128) >> 8;
				pt.z = p[31:0];
				pt.x = axis_coord(col_cnt, cam_cfg.center_x, cam_cfg.inv_focal_x, pt.z);
				pt.y = axis_coord(row_cnt, cam_cfg.center_y, cam_cfg.inv_focal_y, pt.z);
			end
			pt.color = {px.red, px.green, px.blue};
			point_q.insert(point_q.size(), pt);
		end
		col++;
		if (col >= width) begin
			col = 0;
			row++;
			if (row >= FRAME_MAX_H)
				row = 0;
		end
		col_cnt = col[11:0];
		row_cnt = row[11:0];
	endfunction

	// pixel driver: holds a word until taken, then maybe idles
	always @(posedge clk) begin : pixel_driver
		logic   offer;
		pixel_t px;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_pixel(pixel_on_bus);
				n_pixels++;
			end
			if (!s_tvalid || s_tready) begin
				offer = pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (offer) begin
					px           = pixel_q.pop_front();
					pixel_on_bus = px;
					s_tdata      <= {px.blue, px.green, px.red, px.depth};
					s_tuser      <= px.frame_start;
				end
				s_tvalid <= offer;
			end
		end
	end

	// point monitor and receiver stalls
	always @(posedge clk) begin : point_monitor
		point_t pt;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (point_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected point: expected none, got valid %0b data %h",
						 $time, m_tuser[0], m_tdata);
				end else begin
					pt = point_q.pop_front();
					n_points++;
					if (!pt.valid)
						n_no_depth++;
					if (m_tuser[0] !== pt.valid ||
					    m_tdata[dpb_pkg::COORD_W-1:0] !== pt.x ||
					    m_tdata[2*dpb_pkg::COORD_W-1:dpb_pkg::COORD_W] !== pt.y ||
					    m_tdata[3*dpb_pkg::COORD_W-1:2*dpb_pkg::COORD_W] !== pt.z ||
					    m_tdata[dpb_pkg::OUT_DW-1:3*dpb_pkg::COORD_W] !== pt.color) begin
						n_err++;
						$display("%0t: point mismatch: expected v %0b x %h y %h z %h rgb %h",
							 $time, pt.valid, pt.x, pt.y, pt.z, pt.color);
						$display("%0t:                 actual   v %0b x %h y %h z %h rgb %h",
							 $time, m_tuser[0], m_tdata[dpb_pkg::COORD_W-1:0],
							 m_tdata[2*dpb_pkg::COORD_W-1:dpb_pkg::COORD_W],
							 m_tdata[3*dpb_pkg::COORD_W-1:2*dpb_pkg::COORD_W],
							 m_tdata[dpb_pkg::OUT_DW-1:3*dpb_pkg::COORD_W]);
					end
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0d cycles, %0d points outstanding", cycles, point_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic cfg_write(dpb_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			dpb_pkg::REG_IMAGE_WIDTH:
				cam_cfg.image_width  = val[dpb_pkg::WIDTH_W-1:0];
			dpb_pkg::REG_DOWNSAMPLE:
				cam_cfg.downsample   = val[dpb_pkg::DS_W-1:0];
			dpb_pkg::REG_CENTER_X:
				cam_cfg.center_x     = val[dpb_pkg::CTR_W-1:0];
			dpb_pkg::REG_CENTER_Y:
				cam_cfg.center_y     = val[dpb_pkg::CTR_W-1:0];
			dpb_pkg::REG_INV_FOCAL_X:
				cam_cfg.inv_focal_x  = val[dpb_pkg::GAIN_W-1:0];
			dpb_pkg::REG_INV_FOCAL_Y:
				cam_cfg.inv_focal_y  = val[dpb_pkg::GAIN_W-1:0];
			dpb_pkg::REG_DEPTH_FACTOR:
				cam_cfg.depth_factor = val[dpb_pkg::GAIN_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	// all pixels taken, all points seen, then let a dropped pixel finish
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || s_tvalid || point_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void push_pixel(logic fs, logic [15:0] dep,
					   logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t px;
		px.frame_start = fs;
		px.depth       = dep;
		px.red         = r;
		px.green       = g;
		px.blue        = b;
		pixel_q.insert(pixel_q.size(), px);
	endfunction

	function automatic pixel_t random_pixel(logic fs);
		pixel_t px;
		int     r;
		r              = $urandom_range(99);
		px.frame_start = fs;
		if (r < 10)
			px.depth = '0;
		else if (r < 15)
			px.depth = 16'hFFFF;
		else if (r < 25)
			px.depth = 16'($urandom_range(1, 255));
		else
			px.depth = 16'($urandom());
		px.red   = 8'($urandom());
		px.green = 8'($urandom());
		px.blue  = 8'($urandom());
		return px;
	endfunction

	function automatic logic [31:0] pick_cfg(dpb_pkg::reg_idx_t idx);
		int          r, w;
		logic [31:0] v;
		r = $urandom_range(99);
		case (idx)
			dpb_pkg::REG_IMAGE_WIDTH: begin
				w = dpb_pkg::WIDTH_W;
				if (r < 5)       v = 0;
				else if (r < 10) v = $urandom_range(FRAME_MAX_W + 1, 8191);
				else if (r < 15) v = FRAME_MAX_W;
				else             v = $urandom_range(1, 20);
			end
			dpb_pkg::REG_DOWNSAMPLE: begin
				w = dpb_pkg::DS_W;
				if (r < 10)      v = 0;
				else if (r < 15) v = $urandom_range(17, 31);
				else if (r < 20) v = 16;
				else             v = $urandom_range(1, 4);
			end
			dpb_pkg::REG_CENTER_X, dpb_pkg::REG_CENTER_Y: begin
				w = dpb_pkg::CTR_W;
				if (r < 15)      v = 0;
				else if (r < 30) v = 16'hFFFF;
				else if (r < 65) v = $urandom_range(0, 400);
				else             v = $urandom_range(0, 16'hFFFF);
			end
			dpb_pkg::REG_INV_FOCAL_X, dpb_pkg::REG_INV_FOCAL_Y: begin
				w = dpb_pkg::GAIN_W;
				if (r < 10)      v = 1;
				else if (r < 20) v = 24'hFF_FFFF;
				else if (r < 60) v = $urandom_range(16000, 70000);
				else             v = $urandom_range(1, 24'hFF_FFFF);
			end
			default: begin
				w = dpb_pkg::GAIN_W;
				if (r < 10)      v = 0;
				else if (r < 20) v = 24'hFF_FFFF;
				else if (r < 50) v = $urandom_range(4000, 70000);
				else             v = $urandom_range(0, 24'hFF_FFFF);
			end
		endcase
		// junk above the field now and then; the register keeps its own bits only
		if ($urandom_range(3) == 0)
			v = v | ($urandom() << w);
		return v;
	endfunction

	// mostly runs of whole rows of random pixels, some cut short or restarted
	function automatic void queue_frames(int count);
		int   made, len, k;
		logic fs;
		made = 0;
		while (made < count) begin
			len = eff_width() * $urandom_range(1, 5);
			if (len > 160)
				len = $urandom_range(40, 160);
			if ($urandom_range(9) == 0)
				len = $urandom_range(1, len);
			for (k = 0; k < len; k++) begin
				fs = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
				pixel_q.insert(pixel_q.size(), random_pixel(fs));
			end
			made += len;
		end
	endfunction

	initial begin
		cam_cfg.image_width  = 640;
		cam_cfg.downsample   = 1;
		cam_cfg.center_x     = 5120;
		cam_cfg.center_y     = 3840;
		cam_cfg.inv_focal_x  = 32263;
		cam_cfg.inv_focal_y  = 32263;
		cam_cfg.depth_factor = 16777;
		col_cnt              = '0;
		row_cnt              = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults after reset; no-depth pixel and a restart mid-row
		push_pixel(1'b1, 16'd1000, 8'hFF, 8'h00, 8'hAA);
		push_pixel(1'b0, 16'd0,    8'h00, 8'hFF, 8'h55);
		push_pixel(1'b0, 16'hFFFF, 8'h5A, 8'hA5, 8'hFF);
		push_pixel(1'b0, 16'd1,    8'hC3, 8'h3C, 8'h00);
		push_pixel(1'b1, 16'h8000, 8'h81, 8'h7E, 8'h18);
		wait_idle();

		// zero depth factor: valid point at the origin
		cfg_write(dpb_pkg::REG_DEPTH_FACTOR, 32'd0);
		push_pixel(1'b1, 16'hFFFF, 8'h12, 8'h34, 8'h56);
		push_pixel(1'b0, 16'h1234, 8'hFE, 8'hDC, 8'hBA);
		wait_idle();

		// zero width acts as one, zero downsample as one, gains and depth at max
		cfg_write(dpb_pkg::REG_IMAGE_WIDTH,  32'd0);
		cfg_write(dpb_pkg::REG_DOWNSAMPLE,   32'd0);
		cfg_write(dpb_pkg::REG_CENTER_X,     32'd0);
		cfg_write(dpb_pkg::REG_CENTER_Y,     32'hFFFF);
		cfg_write(dpb_pkg::REG_INV_FOCAL_X,  32'hFF_FFFF);
		cfg_write(dpb_pkg::REG_INV_FOCAL_Y,  32'hFF_FFFF);
		cfg_write(dpb_pkg::REG_DEPTH_FACTOR, 32'hFF_FFFF);
		push_pixel(1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(1'b0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
		push_pixel(1'b0, 16'h7FFF, 8'h55, 8'hAA, 8'h55);
		push_pixel(1'b0, 16'd0,    8'hAA, 8'h55, 8'hAA);
		wait_idle();

		// oversized width clamps, downsample beyond 16
		cfg_write(dpb_pkg::REG_IMAGE_WIDTH, 32'h1FFF);
		cfg_write(dpb_pkg::REG_DOWNSAMPLE,  32'd31);
		cfg_write(dpb_pkg::REG_CENTER_X,    32'hFFFF);
		cfg_write(dpb_pkg::REG_CENTER_Y,    32'd0);
		cfg_write(dpb_pkg::REG_INV_FOCAL_X, 32'd1);
		cfg_write(dpb_pkg::REG_INV_FOCAL_Y, 32'd1);
		push_pixel(1'b1, 16'hFFFF, 8'h0F, 8'hF0, 8'h3C);
		push_pixel(1'b0, 16'h0100, 8'hF0, 8'h0F, 8'hC3);
		push_pixel(1'b0, 16'h0001, 8'h99, 8'h66, 8'h99);
		push_pixel(1'b0, 16'hABCD, 8'h66, 8'h99, 8'h66);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			if (ph == RANDOM_PHASES / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 37;
			end else if (ph == 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < 7; i++)
				cfg_write(dpb_pkg::reg_idx_t'(i), pick_cfg(dpb_pkg::reg_idx_t'(i)));
			queue_frames(PHASE_PIXELS);
			// receiver backs off while the whole phase is queued up
			if (ph == 1)
				hold_reqs++;
		end
		wait_idle();

		$display("run covered %0d pixels and %0d checked points (%0d without depth)",
			 n_pixels, n_points, n_no_depth);
		$display("over %0d register writes: directed extremes and %0d random phases",
			 n_writes, RANDOM_PHASES);
		if (n_err == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
